FILE: hdl/firi_pkg.sv
`default_nettype none

package firi_pkg;

  localparam int MAX_TAPS_DEF     = 512;
  localparam int MAX_RATIO_DEF    = 16;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 18;

  localparam int RATIO_RST = 4;
  localparam int TAPS_RST  = 19;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic CFG_IDX_RATIO = 1'b0;
  localparam logic CFG_IDX_TAPS  = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_GAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic acc_clr;
    logic rd_vld;
    logic gain_en;
  } mac_ctrl_t;

  typedef struct packed {
    logic prod_vld;
  } mac_stat_t;

endpackage

`default_nettype wire

FILE: hdl/fir_interpolator.sv
// Channel  Dir  Transaction
// in_      in   tuser: action; tdata: coef_index, coef_value, sample
// out_     out  tdata: out_sample; tlast: final result of the run
// cfg      in   APB register access: ratio @0x0, tap_count @0x4
//
// Sample transaction: the single shared multiply-accumulate walks the taps
//   once per output phase.
// Load writes one coefficient. An unknown action is dropped.
// Reset and flush: a clearing pass over the MAX_TAPS entries (reset clears both tables,
//   flush only the delay line); in_tready is low during it.
// One output register; a stalled output holds the next phase back, not the next input.
`default_nettype none

module fir_interpolator #(
  parameter int MAX_TAPS     = firi_pkg::MAX_TAPS_DEF,
  parameter int MAX_RATIO    = firi_pkg::MAX_RATIO_DEF,
  parameter int SAMPLE_WIDTH = firi_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = firi_pkg::COEF_WIDTH_DEF,
  localparam int AW     = $clog2(MAX_TAPS),
  localparam int IN_DW  = ((AW + COEF_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_DW-1:0]                in_tdata,   // coef_index, coef_value, sample
  input  logic [1:0]                      in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_DW-1:0]               out_tdata,  // out_sample
  output logic                            out_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [firi_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [firi_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [firi_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import firi_pkg::*;

  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int RW = $clog2(MAX_RATIO + 1);

  logic [RW-1:0] ratio_r;
  logic [NW-1:0] taps_r;
  logic          cfg_wr;

  mac_ctrl_t                   mac_ctrl;
  mac_stat_t                   mac_stat;
  logic signed [SAMPLE_WIDTH-1:0] dly_rd;
  logic signed [COEF_WIDTH-1:0]   coef_rd;
  logic signed [SAMPLE_WIDTH-1:0] result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RW'(RATIO_RST);
      taps_r  <= NW'(TAPS_RST);
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_IDX_RATIO) begin
        ratio_r <= pwdata[RW-1:0];
      end else begin
        taps_r <= pwdata[NW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_TAPS) ? CFG_DATA_W'(taps_r) : CFG_DATA_W'(ratio_r);

  firi_ctrl #(
    .MAX_TAPS     (MAX_TAPS),
    .MAX_RATIO    (MAX_RATIO),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .ratio      (ratio_r),
    .tap_count  (taps_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mac_ctrl   (mac_ctrl),
    .mac_stat   (mac_stat),
    .dly_rd     (dly_rd),
    .coef_rd    (coef_rd),
    .result     (result)
  );

  firi_mac #(
    .MAX_TAPS     (MAX_TAPS),
    .MAX_RATIO    (MAX_RATIO),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mac_ctrl),
    .stat    (mac_stat),
    .dly_rd  (dly_rd),
    .coef_rd (coef_rd),
    .result  (result)
  );

endmodule

`default_nettype wire

FILE: hdl/firi_mac.sv
`default_nettype none

module firi_mac #(
  parameter int MAX_TAPS     = firi_pkg::MAX_TAPS_DEF,
  parameter int MAX_RATIO    = firi_pkg::MAX_RATIO_DEF,
  parameter int SAMPLE_WIDTH = firi_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = firi_pkg::COEF_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  firi_pkg::mac_ctrl_t            ctrl,
  output firi_pkg::mac_stat_t            stat,
  input  logic signed [SAMPLE_WIDTH-1:0] dly_rd,
  input  logic signed [COEF_WIDTH-1:0]   coef_rd,
  output logic signed [SAMPLE_WIDTH-1:0] result
);
  import firi_pkg::*;

  localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int AW    = $clog2(MAX_TAPS);
  localparam int ACC_W = PW + AW;
  localparam int GW    = ACC_W + $clog2(MAX_RATIO + 1);
  localparam int SH    = COEF_WIDTH - 1;
  localparam int QW    = GW - SH;

  localparam logic signed [QW-1:0] SAT_HI = QW'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [QW-1:0] SAT_LO = QW'(-(longint'(1) << (SAMPLE_WIDTH - 1)));
  localparam logic [GW-1:0]        HALF   = GW'(1) << (SH - 1);

  logic signed [PW-1:0]    prod_r;
  logic                    prod_vld_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [GW-1:0]    gain_r;
  logic signed [GW-1:0]    rnd;
  logic signed [QW-1:0]    q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_vld) begin
      prod_r <= PW'(dly_rd) * PW'(coef_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc_r  <= '0;
      gain_r <= '0;
    end else begin
      if (prod_vld_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (ctrl.gain_en) begin
        gain_r <= gain_r + GW'(acc_r);
      end
    end
  end

  // round half up, drop the Q1.17 fraction, clamp
  always_comb begin
    rnd = gain_r + HALF;
    q   = rnd[GW-1:SH];
    if (q > SAT_HI) begin
      result = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (q < SAT_LO) begin
      result = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      result = q[SAMPLE_WIDTH-1:0];
    end
  end

  assign stat.prod_vld = prod_vld_r;

endmodule

`default_nettype wire

FILE: hdl/firi_ctrl.sv
`default_nettype none

module firi_ctrl #(
  parameter int MAX_TAPS     = firi_pkg::MAX_TAPS_DEF,
  parameter int MAX_RATIO    = firi_pkg::MAX_RATIO_DEF,
  parameter int SAMPLE_WIDTH = firi_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = firi_pkg::COEF_WIDTH_DEF,
  localparam int AW     = $clog2(MAX_TAPS),
  localparam int NW     = $clog2(MAX_TAPS + 1),
  localparam int RW     = $clog2(MAX_RATIO + 1),
  localparam int IN_DW  = ((AW + COEF_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [RW-1:0]                  ratio,
  input  logic [NW-1:0]                  tap_count,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_DW-1:0]               in_tdata,
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_DW-1:0]              out_tdata,
  output logic                           out_tlast,
  output firi_pkg::mac_ctrl_t            mac_ctrl,
  input  firi_pkg::mac_stat_t            mac_stat,
  output logic signed [SAMPLE_WIDTH-1:0] dly_rd,
  output logic signed [COEF_WIDTH-1:0]   coef_rd,
  input  logic signed [SAMPLE_WIDTH-1:0] result
);
  import firi_pkg::*;

  state_t state_r, state_nxt;

  logic [AW-1:0]           clr_r, clr_nxt;
  logic                    clr_coef_r, clr_coef_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic [RW-1:0]           r_r, r_nxt;
  logic [RW-1:0]           phase_r, phase_nxt;
  logic [RW-1:0]           gcnt_r, gcnt_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [AW-1:0]           tap_r, tap_nxt;
  logic [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [SAMPLE_WIDTH-1:0] dly_mem [MAX_TAPS];
  logic [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
  logic [SAMPLE_WIDTH-1:0] dly_rd_r;
  logic [COEF_WIDTH-1:0]   coef_rd_r;

  logic                    dly_we;
  logic [AW-1:0]           dly_wa;
  logic [SAMPLE_WIDTH-1:0] dly_wd;
  logic                    coef_we;
  logic [AW-1:0]           coef_wa;
  logic [COEF_WIDTH-1:0]   coef_wd;

  action_t                 in_act;
  logic [AW-1:0]           in_idx;
  logic [COEF_WIDTH-1:0]   in_coef;
  logic [SAMPLE_WIDTH-1:0] in_sample;
  logic                    in_acc;
  logic [RW-1:0]           r_eff;
  logic [NW-1:0]           n_eff;
  logic [AW-1:0]           pos_start;
  logic [NW-1:0]           pos_inc;
  logic [AW-1:0]           pos_wrap;
  logic                    tap_end;
  logic                    last_phase;
  logic                    gain_end;
  logic                    load_out;

  assign in_act    = action_t'(in_tuser);
  assign in_idx    = in_tdata[AW-1:0];
  assign in_coef   = in_tdata[AW+COEF_WIDTH-1:AW];
  assign in_sample = in_tdata[AW+COEF_WIDTH+SAMPLE_WIDTH-1:AW+COEF_WIDTH];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (ratio == '0) begin
      r_eff = RW'(1);
    end else if (ratio > RW'(MAX_RATIO)) begin
      r_eff = RW'(MAX_RATIO);
    end else begin
      r_eff = ratio;
    end
    if (tap_count == '0) begin
      n_eff = NW'(1);
    end else if (tap_count > NW'(MAX_TAPS)) begin
      n_eff = NW'(MAX_TAPS);
    end else begin
      n_eff = tap_count;
    end
  end

  // a lowered tap count can leave the position stale
  assign pos_start  = (NW'(pos_r) >= n_eff) ? '0 : pos_r;
  assign pos_inc    = NW'(pos_r) + NW'(1);
  assign pos_wrap   = (pos_inc >= n_r) ? '0 : pos_inc[AW-1:0];
  assign tap_end    = (NW'(tap_r) == n_r - NW'(1));
  assign last_phase = (phase_r == r_r - RW'(1));
  assign gain_end   = (gcnt_r == r_r - RW'(1));
  assign load_out   = (state_r == ST_RESULT) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(MAX_TAPS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_act)
            ACT_SAMPLE: state_nxt = ST_WRITE;
            ACT_FLUSH:  state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: state_nxt = ST_MAC;
      ST_MAC: begin
        if (tap_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !mac_stat.prod_vld) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (gain_end) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (load_out) begin
          state_nxt = last_phase ? ST_IDLE : ST_WRITE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt      = clr_r;
    clr_coef_nxt = clr_coef_r;
    pos_nxt      = pos_r;
    n_nxt        = n_r;
    r_nxt        = r_r;
    phase_nxt    = phase_r;
    gcnt_nxt     = gcnt_r;
    idx_nxt      = idx_r;
    tap_nxt      = tap_r;
    sample_nxt   = sample_r;
    rd_vld_nxt   = 1'b0;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    dly_we       = 1'b0;
    dly_wa       = clr_r;
    dly_wd       = '0;
    coef_we      = 1'b0;
    coef_wa      = clr_r;
    coef_wd      = '0;
    mac_ctrl     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        dly_we  = 1'b1;
        coef_we = clr_coef_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_TAPS - 1)) begin
          clr_coef_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_act)
            ACT_LOAD: begin
              coef_we = (NW'(in_idx) < NW'(MAX_TAPS));
              coef_wa = in_idx;
              coef_wd = in_coef;
            end
            ACT_SAMPLE: begin
              sample_nxt = in_sample;
              r_nxt      = r_eff;
              n_nxt      = n_eff;
              pos_nxt    = pos_start;
              phase_nxt  = '0;
            end
            ACT_FLUSH: begin
              clr_nxt = '0;
              pos_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        dly_we           = 1'b1;
        dly_wa           = pos_r;
        dly_wd           = (phase_r == '0) ? sample_r : '0;
        idx_nxt          = pos_r;
        tap_nxt          = '0;
        gcnt_nxt         = '0;
        mac_ctrl.acc_clr = 1'b1;
      end
      ST_MAC: begin
        rd_vld_nxt = 1'b1;
        tap_nxt    = tap_r + AW'(1);
        idx_nxt    = (idx_r == '0) ? AW'(n_r - NW'(1)) : idx_r - AW'(1);
      end
      ST_DRAIN: ;
      ST_GAIN: begin
        mac_ctrl.gain_en = 1'b1;
        gcnt_nxt         = gcnt_r + RW'(1);
      end
      ST_RESULT: begin
        if (load_out) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = result;
          out_last_nxt = last_phase;
          pos_nxt      = pos_wrap;
          phase_nxt    = phase_r + RW'(1);
        end
      end
      default: ;
    endcase
    mac_ctrl.rd_vld = rd_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      clr_coef_r <= 1'b1;
      pos_r      <= '0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      clr_coef_r <= clr_coef_nxt;
      pos_r      <= pos_nxt;
      rd_vld_r   <= rd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    r_r        <= r_nxt;
    phase_r    <= phase_nxt;
    gcnt_r     <= gcnt_nxt;
    idx_r      <= idx_nxt;
    tap_r      <= tap_nxt;
    sample_r   <= sample_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    dly_rd_r <= dly_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    coef_rd_r <= coef_mem[tap_r];
  end

  assign dly_rd     = dly_rd_r;
  assign coef_rd    = coef_rd_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DW'(out_data_r);
  assign out_tlast  = out_last_r;

  a_rd_from_mac: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r) == ST_MAC)
    else $error("read data flagged valid outside the tap sweep");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (NW'(pos_r) < n_r))
    else $error("write position beyond tap count");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (phase_r < r_r))
    else $error("phase beyond ratio");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && last_phase) |=> (state_r == ST_IDLE && out_vld_r && out_last_r))
    else $error("final result of a run not flagged or sequencer not idle");

endmodule

`default_nettype wire
